/* rtl/core/its_pkg.sv */
// shared types, constants and helpers of the identifier token substituter
`timescale 1ns / 1ps
`default_nettype none

package its_pkg;

   // table geometry
   localparam int ENTRIES      = 8;
   localparam int STRING_BYTES = 16;
   localparam int RUN_MAX      = STRING_BYTES - 1;
   localparam int ENT_W        = $clog2(ENTRIES);
   localparam int POS_W        = $clog2(STRING_BYTES);
   localparam int ADDR_W       = ENT_W + POS_W;
   localparam int TBL_DEPTH    = ENTRIES * STRING_BYTES;
   localparam int CNT_W        = 4;
   localparam int BYTE_W       = 8;

   // command codes carried in the low bits of req_tuser
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_TEXT  = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   // table part select
   localparam logic PART_KEY   = 1'b0;
   localparam logic PART_VALUE = 1'b1;

   localparam logic [BYTE_W-1:0] UNDERSCORE = 8'h5f;

   // verdict of the byte compare unit
   typedef struct packed {
      logic byte_ok;   // key byte agrees with the run at this position
      logic last_pos;  // this position decides the whole key
   } cmp_res_type;

   // letters, digits and underscore
   function automatic logic is_ident(input logic [BYTE_W-1:0] c);
      logic r;
      r = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
          ((c >= 8'h30) && (c <= 8'h39)) || (c == UNDERSCORE);
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/its_ram.sv */
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module its_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port share the address
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule

`default_nettype wire

/* rtl/core/its_cmp.sv */
// byte compare unit shared by every key position of every entry
`timescale 1ns / 1ps
`default_nettype none

module its_cmp (
   input  wire logic [its_pkg::BYTE_W-1:0] key_byte,
   input  wire logic [its_pkg::BYTE_W-1:0] run_byte,
   input  wire logic [its_pkg::CNT_W-1:0]  idx,
   input  wire logic [its_pkg::CNT_W-1:0]  run_len,
   output its_pkg::cmp_res_type            res
);
   import its_pkg::*;

   logic inside_run;
   logic at_full_end;

   // inside the run the bytes must agree, just past it the key must end
   assign inside_run  = (idx < run_len);
   assign at_full_end = (run_len == CNT_W'(RUN_MAX)) && ((idx + 1'b1) == run_len);

   always_comb begin
      res.byte_ok  = inside_run ? (key_byte == run_byte) : (key_byte == '0);
      res.last_pos = !inside_run || at_full_end;
   end

endmodule

`default_nettype wire

/* rtl/core/identifier_token_substituter.sv */
// Identifier token substituter: collects identifier runs and swaps matching keys for values.
// The req channel carries one command per transfer: a table write, a text byte or an
// end-of-text flush (command and key/value select in req_tuser). The rsp channel returns
// output text bytes one per transfer, with rsp_tlast on the final byte caused by a request.
// csr writes the number of table entries searched; csr_ready is always high.
// Table writes, identifier bytes that only extend a run, and empty flushes give no output.
// A delimiter or flush that ends a run searches the key table with one
// shared byte compare unit, checking each key byte with a ram read then a compare, up to
// 15 positions per entry and up to 8 entries, then emits the value with one byte of
// lookahead to find its end, or the run itself, then the delimiter.
// Each key or value byte takes a read state and a check state, as the ram read is registered.
// req_tready is low while a request is being worked on.
// Output bytes leave through a single output register: while rsp_tready is low the
// sequencer holds, and a finished last byte may wait there while the next request is taken.
// Reset clears the run, the entry count and the output register; the key and value tables
// are not cleared and must be written before use.
`timescale 1ns / 1ps
`default_nettype none

module identifier_token_substituter (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // entry[2:0], pos[6:3], data_byte[14:7], zero[15]
   input  wire logic [2:0]  req_tuser,  // cmd[1:0], part[2]
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // out_byte[7:0]
   output logic             rsp_tlast,
   // entry count register
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_data
);
   import its_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_KEY_RD   = 3'd1;
   localparam logic [2:0] S_KEY_CK   = 3'd2;
   localparam logic [2:0] S_VAL_RD   = 3'd3;
   localparam logic [2:0] S_VAL_CK   = 3'd4;
   localparam logic [2:0] S_RUN_EMIT = 3'd5;
   localparam logic [2:0] S_TAIL     = 3'd6;

   // request fields
   logic [1:0]        req_cmd;
   logic              req_part;
   logic [ENT_W-1:0]  req_entry;
   logic [POS_W-1:0]  req_pos;
   logic [BYTE_W-1:0] req_byte;
   logic              req_fire;

   assign req_cmd   = req_tuser[1:0];
   assign req_part  = req_tuser[2];
   assign req_entry = req_tdata[2:0];
   assign req_pos   = req_tdata[6:3];
   assign req_byte  = req_tdata[14:7];
   assign req_fire  = req_tvalid && req_tready;

   // state
   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  run_len_ff, run_len_in;
   logic              overlong_ff, overlong_in;
   logic [CNT_W-1:0]  ent_ff, ent_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              tail_ff, tail_in;
   logic [BYTE_W-1:0] cur_byte_ff, cur_byte_in;
   logic [BYTE_W-1:0] hold_ff, hold_in;
   logic              hold_vld_ff, hold_vld_in;
   logic [CNT_W-1:0]  entries_ff, entries_in;
   logic [BYTE_W-1:0] run_buf_ff [RUN_MAX];
   logic [BYTE_W-1:0] run_buf_in;
   logic              buf_we;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   // emission request from the sequencer
   logic              emit_vld;
   logic [BYTE_W-1:0] emit_byte;
   logic              emit_last;
   logic              slot_free;

   // tables
   logic              key_we, val_we;
   logic [ADDR_W-1:0] tbl_addr;
   logic [BYTE_W-1:0] key_rdata, val_rdata;

   logic [CNT_W-1:0]  lim;
   logic [BYTE_W-1:0] run_rd_byte;
   cmp_res_type       cmp_res;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // searched entry count, clamped to the table size
   assign lim = (entries_ff > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : entries_ff;

   // table port: write address while idle, sequencer address otherwise
   assign key_we   = req_fire && (req_cmd == CMD_WRITE) && (req_part == PART_KEY);
   assign val_we   = req_fire && (req_cmd == CMD_WRITE) && (req_part == PART_VALUE);
   assign tbl_addr = (state_ff == S_IDLE) ? {req_entry, req_pos}
                                          : {ent_ff[ENT_W-1:0], idx_ff[POS_W-1:0]};

   its_ram #(.WIDTH(BYTE_W), .DEPTH(TBL_DEPTH)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .addr  (tbl_addr),
      .wdata (req_byte),
      .rdata (key_rdata)
   );

   its_ram #(.WIDTH(BYTE_W), .DEPTH(TBL_DEPTH)) u_val_ram (
      .clock (clock),
      .we    (val_we),
      .addr  (tbl_addr),
      .wdata (req_byte),
      .rdata (val_rdata)
   );

   // run byte under the compare or emit pointer, never past the last slot
   assign run_rd_byte = (idx_ff < CNT_W'(RUN_MAX)) ? run_buf_ff[idx_ff] : '0;

   its_cmp u_cmp (
      .key_byte (key_rdata),
      .run_byte (run_rd_byte),
      .idx      (idx_ff),
      .run_len  (run_len_ff),
      .res      (cmp_res)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      run_len_in  = run_len_ff;
      overlong_in = overlong_ff;
      ent_in      = ent_ff;
      idx_in      = idx_ff;
      tail_in     = tail_ff;
      cur_byte_in = cur_byte_ff;
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      buf_we      = 1'b0;
      run_buf_in  = req_byte;
      emit_vld    = 1'b0;
      emit_byte   = cur_byte_ff;
      emit_last   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cur_byte_in = req_byte;
               idx_in      = '0;
               ent_in      = '0;
               hold_vld_in = 1'b0;
               // a delimiter text byte or a flush ends the pending run
               if ((req_cmd == CMD_TEXT && !is_ident(req_byte)) || req_cmd == CMD_FLUSH) begin
                  tail_in = (req_cmd == CMD_TEXT);
                  if (overlong_ff || run_len_ff == '0) begin
                     run_len_in  = '0;
                     overlong_in = 1'b0;
                     state_in    = (req_cmd == CMD_TEXT) ? S_TAIL : S_IDLE;
                  end else if (lim == '0) begin
                     state_in = S_RUN_EMIT;
                  end else begin
                     state_in = S_KEY_RD;
                  end
               end else if (req_cmd == CMD_TEXT) begin
                  tail_in = 1'b1;
                  if (overlong_ff) begin
                     state_in = S_TAIL;
                  end else if (run_len_ff < CNT_W'(RUN_MAX)) begin
                     buf_we     = 1'b1;
                     run_len_in = run_len_ff + 1'b1;
                  end else begin
                     // full run with one more identifier byte: flush it all
                     overlong_in = 1'b1;
                     state_in    = S_RUN_EMIT;
                  end
               end
            end
         end

         S_KEY_RD: begin
            state_in = S_KEY_CK;
         end

         S_KEY_CK: begin
            if (cmp_res.byte_ok && cmp_res.last_pos) begin
               idx_in   = '0;
               state_in = S_VAL_RD;
            end else if (cmp_res.byte_ok) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_KEY_RD;
            end else if ((ent_ff + 1'b1) == lim) begin
               idx_in   = '0;
               state_in = S_RUN_EMIT;
            end else begin
               ent_in   = ent_ff + 1'b1;
               idx_in   = '0;
               state_in = S_KEY_RD;
            end
         end

         S_VAL_RD: begin
            state_in = S_VAL_CK;
         end

         S_VAL_CK: begin
            // one byte of lookahead so the final byte can carry last
            if (idx_ff == CNT_W'(RUN_MAX) || val_rdata == '0) begin
               if (!hold_vld_ff || slot_free) begin
                  emit_vld    = hold_vld_ff;
                  emit_byte   = hold_ff;
                  emit_last   = !tail_ff;
                  hold_vld_in = 1'b0;
                  run_len_in  = '0;
                  overlong_in = 1'b0;
                  state_in    = tail_ff ? S_TAIL : S_IDLE;
               end
            end else if (!hold_vld_ff || slot_free) begin
               emit_vld    = hold_vld_ff;
               emit_byte   = hold_ff;
               hold_in     = val_rdata;
               hold_vld_in = 1'b1;
               idx_in      = idx_ff + 1'b1;
               state_in    = S_VAL_RD;
            end
         end

         S_RUN_EMIT: begin
            emit_vld  = 1'b1;
            emit_byte = run_rd_byte;
            emit_last = !tail_ff && ((idx_ff + 1'b1) == run_len_ff);
            if (slot_free) begin
               if ((idx_ff + 1'b1) == run_len_ff) begin
                  run_len_in = '0;
                  state_in   = tail_ff ? S_TAIL : S_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         S_TAIL: begin
            emit_vld  = 1'b1;
            emit_byte = cur_byte_ff;
            emit_last = 1'b1;
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register: load on emission, drain on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_vld && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_byte;
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // entry count register
   assign entries_in = (csr_valid && csr_ready) ? csr_data : entries_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         run_len_ff   <= '0;
         overlong_ff  <= 1'b0;
         entries_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         hold_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_len_ff   <= run_len_in;
         overlong_ff  <= overlong_in;
         entries_ff   <= entries_in;
         rsp_valid_ff <= rsp_valid_in;
         hold_vld_ff  <= hold_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ent_ff      <= ent_in;
      idx_ff      <= idx_in;
      tail_ff     <= tail_in;
      cur_byte_ff <= cur_byte_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (buf_we) begin
         run_buf_ff[run_len_ff] <= run_buf_in;
      end
   end

   // run length never exceeds the buffer
   assert property (@(posedge clock) disable iff (reset)
      run_len_ff <= CNT_W'(RUN_MAX))
      else $error("run length past buffer size");

   // an overlong run leaves nothing buffered once its flush is done
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && overlong_ff) |-> (run_len_ff == '0))
      else $error("overlong run with buffered bytes");

   // the key search stays inside the searched entries
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_KEY_RD || state_ff == S_KEY_CK) |-> (ent_ff < lim))
      else $error("key search past entry count");

   // a stalled output byte stays put until it is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=>
      (rsp_valid_ff && $stable(rsp_data_ff) && $stable(rsp_last_ff)))
      else $error("output byte overwritten while stalled");

endmodule

`default_nettype wire

/* dv/tb_identifier_token_substituter.sv */
// testbench for the identifier token substituter: table loads, text stream, checked output bytes
`timescale 1ns / 1ps

module tb_identifier_token_substituter;
   import its_pkg::*;

   localparam int SETTLE_CYCLES = 400;   // longest key search plus value output, with margin
   localparam int STALL_LIMIT   = 4000;

   // one request as it travels on req_tdata / req_tuser
   typedef struct packed {
      logic [1:0] cmd;
      logic [2:0] entry;
      logic       part;
      logic [3:0] pos;
      logic [7:0] data_byte;
   } text_req_type;

   // one output byte as expected on the rsp channel
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } text_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;  // entry[2:0], pos[6:3], data_byte[14:7], zero[15]
   logic [2:0]  req_tuser = '0;  // cmd[1:0], part[2]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;       // out_byte[7:0]
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_data = '0;

   text_req_type pending_reqs [$];
   text_out_type expected_text [$];
   logic [7:0]  step_out [$];
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          phase_cfg [6];
   string       key_text [ENTRIES];
   int          val_len [ENTRIES];

   // shadow copy of the block state
   logic [7:0]  key_tbl [TBL_DEPTH];
   logic [7:0]  value_tbl [TBL_DEPTH];
   logic [7:0]  run_buf [RUN_MAX];
   int          run_len = 0;
   bit          run_long = 1'b0;
   logic [3:0]  entries_cfg = 4'd0;

   identifier_token_substituter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // letters, digits and underscore
   function automatic bit ident_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || c == "_";
   endfunction

   // length of a stored string, stops at the first zero among the first RUN_MAX bytes
   function automatic int stored_len(input bit from_value, input int base);
      int n;
      n = 0;
      while (n < RUN_MAX && (from_value ? value_tbl[base + n] : key_tbl[base + n]) != 8'h00)
         n++;
      return n;
   endfunction

   // end of an identifier run: substitute on the first matching key, else echo the run
   function automatic void close_run();
      int lim, e, i, base, vlen;
      bit hit;
      hit = 1'b0;
      if (!run_long && run_len > 0) begin
         lim = (entries_cfg > ENTRIES) ? ENTRIES : entries_cfg;
         for (e = 0; e < lim && !hit; e++) begin
            base = e * STRING_BYTES;
            if (stored_len(1'b0, base) == run_len) begin
               hit = 1'b1;
               for (i = 0; i < run_len; i++)
                  if (key_tbl[base + i] != run_buf[i]) hit = 1'b0;
               if (hit) begin
                  vlen = stored_len(1'b1, base);
                  for (i = 0; i < vlen; i++) step_out.push_back(value_tbl[base + i]);
               end
            end
         end
         if (!hit)
            for (i = 0; i < run_len; i++) step_out.push_back(run_buf[i]);
      end
      run_len = 0;
      run_long = 1'b0;
   endfunction

   // expected output bytes of one accepted request
   function automatic void predict_substitution(input logic [1:0] cmd, input logic [2:0] entry,
                                                input logic part, input logic [3:0] pos,
                                                input logic [7:0] b);
      int i;
      text_out_type o;
      step_out.delete();
      case (cmd)
         CMD_WRITE: begin
            if (part == PART_VALUE) value_tbl[entry * STRING_BYTES + pos] = b;
            else key_tbl[entry * STRING_BYTES + pos] = b;
         end
         CMD_TEXT: begin
            if (ident_char(b)) begin
               if (run_long) begin
                  step_out.push_back(b);
               end else if (run_len < RUN_MAX) begin
                  run_buf[run_len] = b;
                  run_len++;
               end else begin
                  // overlong run: spill the buffer and pass the rest through
                  for (i = 0; i < RUN_MAX; i++) step_out.push_back(run_buf[i]);
                  step_out.push_back(b);
                  run_len = 0;
                  run_long = 1'b1;
               end
            end else begin
               close_run();
               step_out.push_back(b);
            end
         end
         CMD_FLUSH: close_run();
         default: ;
      endcase
      for (i = 0; i < step_out.size(); i++) begin
         o.out_byte = step_out[i];
         o.last = (i == step_out.size() - 1);
         expected_text.push_back(o);
      end
   endfunction

   // request driver, predicts on each accepted transfer
   always @(posedge clock) begin : req_driver
      text_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            predict_substitution(req_tuser[1:0], req_tdata[2:0], req_tuser[2],
                                 req_tdata[6:3], req_tdata[14:7]);
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, nxt.data_byte, nxt.pos, nxt.entry};
               req_tuser  <= {nxt.part, nxt.cmd};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random backpressure
   always @(posedge clock) begin : rsp_monitor
      text_out_type want;
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_text.size() == 0) begin
            $error("unexpected rsp transfer: out_byte %h last %b", rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = expected_text.pop_front();
            if (rsp_tdata !== want.out_byte) begin
               $error("out_byte: expected %h, actual %h", want.out_byte, rsp_tdata);
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %b, actual %b", want.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   task automatic push_req(input logic [1:0] cmd, input logic [2:0] entry, input logic part,
                           input logic [3:0] pos, input logic [7:0] b);
      text_req_type r;
      r.cmd = cmd;
      r.entry = entry;
      r.part = part;
      r.pos = pos;
      r.data_byte = b;
      pending_reqs.push_back(r);
   endtask

   // text and flush requests carry random noise in the unused fields
   task automatic push_text_byte(input logic [7:0] b);
      push_req(CMD_TEXT, 3'($urandom_range(7)), 1'($urandom_range(1)),
               4'($urandom_range(15)), b);
   endtask

   task automatic push_flush();
      push_req(CMD_FLUSH, 3'($urandom_range(7)), 1'($urandom_range(1)),
               4'($urandom_range(15)), 8'($urandom_range(255)));
   endtask

   task automatic push_word(input string s);
      for (int i = 0; i < s.len(); i++) push_text_byte(s[i]);
   endtask

   function automatic logic [7:0] rand_ident();
      int r;
      r = $urandom_range(62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r < 62) return 8'("0" + r - 52);
      return "_";
   endfunction

   function automatic logic [7:0] rand_delim();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (ident_char(b));
      return b;
   endfunction

   // string byte at a position: terminator after the text, junk beyond it
   function automatic logic [7:0] fill_byte(input string s, input int p);
      if (p < s.len()) return s[p];
      if (p == s.len()) return 8'h00;
      return 8'($urandom_range(255));
   endfunction

   // write one key/value pair up to and including its terminator, cut at the string size
   task automatic load_entry(input int e, input string k, input string v);
      for (int p = 0; p <= k.len() && p < STRING_BYTES; p++)
         push_req(CMD_WRITE, 3'(e), PART_KEY, 4'(p), fill_byte(k, p));
      for (int p = 0; p <= v.len() && p < STRING_BYTES; p++)
         push_req(CMD_WRITE, 3'(e), PART_VALUE, 4'(p), fill_byte(v, p));
      key_text[e] = k;
      val_len[e] = (v.len() > RUN_MAX) ? RUN_MAX : v.len();
   endtask

   // block idle: nothing queued, nothing in flight, then settle
   task automatic wait_quiet();
      @(posedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_text.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_entries_in_use(input logic [3:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      entries_cfg = v;
   endtask

   // mostly words and known keys with delimiters, some writes, flushes and noise
   task automatic random_text(input int target);
      int sent, r, len, e, p;
      string w;
      logic [7:0] b;
      sent = 0;
      while (sent < target) begin
         r = $urandom_range(99);
         len = 0;
         if (r < 45) begin
            w = key_text[$urandom_range(ENTRIES - 1)];
            if (w.len() == 0) w = "k";
            push_word(w);
            len = w.len();
         end else if (r < 72) begin
            len = $urandom_range(6, 1);
            repeat (len) push_text_byte(rand_ident());
         end else if (r < 78) begin
            len = $urandom_range(20, 13);
            repeat (len) push_text_byte(rand_ident());
         end else if (r < 86) begin
            // value bytes inside the written string, or the ignored last key position
            if ($urandom_range(3) == 0) begin
               push_req(CMD_WRITE, 3'($urandom_range(7)), PART_KEY, 4'd15,
                        8'($urandom_range(255)));
            end else begin
               e = $urandom_range(ENTRIES - 1);
               p = $urandom_range(val_len[e]);
               b = 8'($urandom_range(255));
               if (p < val_len[e]) begin
                  if (b == 8'h00) val_len[e] = p;
               end else if (p < RUN_MAX) begin
                  b = 8'h00;
               end
               push_req(CMD_WRITE, 3'(e), PART_VALUE, 4'(p), b);
            end
            sent++;
         end else if (r < 89) begin
            push_req(CMD_NONE, 3'($urandom_range(7)), 1'($urandom_range(1)),
                     4'($urandom_range(15)), 8'($urandom_range(255)));
         end else begin
            push_flush();
            sent++;
         end
         if (len > 0) begin
            sent += len;
            r = $urandom_range(99);
            if (r < 75) begin
               push_text_byte(rand_delim());
               sent++;
            end else if (r < 93) begin
               push_flush();
               sent++;
            end
         end
      end
   endtask

   initial begin : stimulus
      phase_cfg = '{0, 3, 15, 1, 8, 5};
      send_idle_pct = 11;
      recv_idle_pct = 54;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_entries_in_use(4'd8);

      // full table load, duplicate key on entry 5, empty key on entry 2
      load_entry(0, "id", "identifier");
      load_entry(1, "Zz9", "");
      load_entry(2, "", "never");
      load_entry(3, "ABCDEFGHIJKLMNO", "0123456789abcdefXYZ");
      load_entry(4, "foo_1", "bar");
      load_entry(5, "id", "dup");
      load_entry(6, "x", "y_1");
      load_entry(7, "_", "__");

      // directed: match with high delimiter, miss with flush, empty flush,
      // unknown command, zero delimiter, overlong run then pass-through
      push_word("id");
      push_text_byte(8'hff);
      push_word("q");
      push_flush();
      push_flush();
      push_req(CMD_NONE, 3'd7, PART_VALUE, 4'd15, 8'hff);
      push_text_byte(8'h00);
      push_word("abcdefghijklmnop");
      push_word("Z");
      push_text_byte(".");

      for (int p = 0; p < 6; p++) begin
         wait_quiet();
         write_entries_in_use(4'(phase_cfg[p]));
         if (p == 3) load_entry(2, "tmp", "T");
         send_idle_pct = (p / 2 == 0) ? 11 : (p / 2 == 1) ? 54 : 0;
         recv_idle_pct = (p / 2 == 0) ? 54 : (p / 2 == 1) ? 11 : 0;
         random_text(36);
      end
      push_flush();
      wait_quiet();

      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
